// File: src/msva_pkg.sv
// Shared constants, codes and types of the mono/stereo voice allocator.
package msva_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int CH_W         = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NUM_PAIRS    = NUM_CHANNELS / 2;
  localparam int NUM_ROWS     = (NUM_CHANNELS + 1) / 2;
  localparam int ROW_W        = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 6;
  localparam int OWNER_W = 32;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_MONO   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEREO = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OWNER  = 2'd2;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_MONO  = 2'd1;
  localparam logic [1:0] ST_LEFT  = 2'd2;
  localparam logic [1:0] ST_RIGHT = 2'd3;

  typedef struct packed {
    logic latch;  // capture a request word and read the owner rows
    logic exec;   // update the tables and load the result register
  } msva_cmd_t;

endpackage

// File: src/msva_req_if.sv
// Request channel: valid/ready handshake with command, channel and owner.
interface msva_req_if import msva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CHAN_W-1:0]  channel;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, cmd, channel, owner_id, input ready);
  modport sink   (input valid, cmd, channel, owner_id, output ready);
endinterface

// File: src/msva_rsp_if.sv
// Response channel: valid/ready handshake with status and granted channel.
interface msva_rsp_if import msva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [CHAN_W-1:0] granted_channel;

  modport source (output valid, status, granted_channel, input ready);
  modport sink   (input valid, status, granted_channel, output ready);
endinterface

// File: src/msva_ctrl.sv
// Controller: two-state sequencer and result-register occupancy.
module msva_ctrl import msva_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output msva_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready  = (state == S_IDLE);
  assign cmd.latch = in_valid && in_ready;
  assign cmd.exec  = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.latch) state_next = S_EXEC;
      S_EXEC: if (cmd.exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/msva_dp.sv
// Datapath: channel state flags, banked owner memory, search and result register.
module msva_dp import msva_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  msva_cmd_t          cmd,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [CHAN_W-1:0]  in_channel,
  input  logic [OWNER_W-1:0] in_owner_id,
  output logic [STAT_W-1:0]  status,
  output logic [CHAN_W-1:0]  granted_channel
);

  // Lowest set bit of a NUM_CHANNELS-wide vector, as found flag plus index.
  function automatic logic [CH_W:0] find_first(input logic [NUM_CHANNELS-1:0] v);
    logic [NUM_CHANNELS-1:0] onehot;
    logic [CH_W-1:0]         idx;
    onehot = v & (~v + NUM_CHANNELS'(1));
    idx    = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (onehot[i]) idx = idx | CH_W'(i);
    end
    return {|v, idx};
  endfunction

  // Per-channel state flags, cleared by reset.
  logic [1:0]         alloc_st [NUM_CHANNELS];
  logic               own_vld  [2*NUM_ROWS];
  // Owner ids, even and odd channels in separate banks sharing a row address.
  logic [OWNER_W-1:0] mem_even [NUM_ROWS];
  logic [OWNER_W-1:0] mem_odd  [NUM_ROWS];

  logic [NUM_CHANNELS-1:0] free_vec;
  logic [NUM_CHANNELS-1:0] pair_vec;
  logic [CH_W:0]           mono_hit;
  logic [CH_W:0]           pair_hit;
  logic [CH_W-1:0]         in_idx;
  logic [ROW_W-1:0]        in_row;

  always_comb begin
    free_vec = '0;
    pair_vec = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      free_vec[i] = (alloc_st[i] == ST_FREE);
    end
    for (int k = 0; k < NUM_PAIRS; k++) begin
      pair_vec[k] = free_vec[2*k] && free_vec[2*k+1];
    end
  end

  assign mono_hit = find_first(free_vec);
  assign pair_hit = find_first(pair_vec);
  assign in_idx   = CH_W'(in_channel);
  assign in_row   = ROW_W'(in_idx >> 1);

  // Latched request and search results.
  logic [CMD_W-1:0]   r_cmd;
  logic [CHAN_W-1:0]  r_ch;
  logic [OWNER_W-1:0] r_owner;
  logic [OWNER_W-1:0] rd_even;
  logic [OWNER_W-1:0] rd_odd;
  logic               mono_found;
  logic [CH_W-1:0]    mono_idx;
  logic               pair_found;
  logic [CH_W-1:0]    pair_idx;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_cmd      <= in_cmd;
      r_ch       <= in_channel;
      r_owner    <= in_owner_id;
      rd_even    <= mem_even[in_row];
      rd_odd     <= mem_odd[in_row];
      mono_found <= mono_hit[CH_W];
      mono_idx   <= mono_hit[CH_W-1:0];
      pair_found <= pair_hit[CH_W];
      pair_idx   <= pair_hit[CH_W-1:0];
    end
  end

  // Execute step.
  logic [CH_W-1:0]    r_idx;
  logic [CH_W-1:0]    p_idx;
  logic [CH_W-1:0]    left_idx;
  logic [CH_W-1:0]    right_idx;
  logic [OWNER_W-1:0] own_cur;
  logic [OWNER_W-1:0] own_par;
  logic               in_range;
  logic [STAT_W-1:0]  status_next;
  logic [CHAN_W-1:0]  granted_next;
  logic               set_mono;
  logic               set_pair;
  logic               rel_cur;
  logic               rel_par;

  assign r_idx     = CH_W'(r_ch);
  assign p_idx     = r_idx ^ CH_W'(1);
  assign left_idx  = CH_W'(pair_idx << 1);
  assign right_idx = left_idx | CH_W'(1);
  assign in_range  = 32'(r_ch) < 32'(NUM_CHANNELS);
  assign own_cur   = own_vld[r_idx] ? (r_idx[0] ? rd_odd : rd_even) : '0;
  assign own_par   = own_vld[p_idx] ? (p_idx[0] ? rd_odd : rd_even) : '0;

  always_comb begin
    status_next  = STAT_NOFREE;
    granted_next = '0;
    set_mono     = 1'b0;
    set_pair     = 1'b0;
    rel_cur      = 1'b0;
    rel_par      = 1'b0;
    case (r_cmd)
      CMD_MONO: begin
        if (mono_found) begin
          set_mono     = 1'b1;
          status_next  = STAT_OK;
          granted_next = CHAN_W'(mono_idx);
        end
      end
      CMD_FREE: begin
        granted_next = r_ch;
        if (!in_range) begin
          status_next = STAT_NOFREE;
        end else if (own_cur != r_owner) begin
          status_next = STAT_OWNER;
        end else begin
          status_next = STAT_OK;
          rel_cur     = 1'b1;
          // Partner of a stereo channel is its even/odd neighbor.
          if ((alloc_st[r_idx] == ST_LEFT || alloc_st[r_idx] == ST_RIGHT) &&
              32'(p_idx) < 32'(NUM_CHANNELS) && own_par == r_owner) begin
            rel_par = 1'b1;
          end
        end
      end
      default: begin
        // Stereo request; the unused code acts the same.
        if (pair_found) begin
          set_pair     = 1'b1;
          status_next  = STAT_OK;
          granted_next = CHAN_W'(left_idx);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) alloc_st[i] <= ST_FREE;
      for (int i = 0; i < 2*NUM_ROWS; i++) own_vld[i] <= 1'b0;
    end else if (cmd.exec) begin
      if (set_mono) begin
        alloc_st[mono_idx] <= ST_MONO;
        own_vld[mono_idx]  <= 1'b1;
      end
      if (set_pair) begin
        alloc_st[left_idx]  <= ST_LEFT;
        alloc_st[right_idx] <= ST_RIGHT;
        own_vld[left_idx]   <= 1'b1;
        own_vld[right_idx]  <= 1'b1;
      end
      // A cleared valid bit reads the owner back as zero.
      if (rel_cur) begin
        alloc_st[r_idx] <= ST_FREE;
        own_vld[r_idx]  <= 1'b0;
      end
      if (rel_par) begin
        alloc_st[p_idx] <= ST_FREE;
        own_vld[p_idx]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (set_mono && !mono_idx[0]) mem_even[ROW_W'(mono_idx >> 1)] <= r_owner;
      if (set_mono && mono_idx[0])  mem_odd[ROW_W'(mono_idx >> 1)]  <= r_owner;
      if (set_pair) begin
        mem_even[ROW_W'(pair_idx)] <= r_owner;
        mem_odd[ROW_W'(pair_idx)]  <= r_owner;
      end
      status          <= status_next;
      granted_channel <= granted_next;
    end
  end

endmodule

// File: src/mono_stereo_voice_allocator_top.sv
// Top level of the mono/stereo voice allocator: controller plus datapath.
//
// Usage:
//   req carries one request word: cmd (allocate mono, allocate stereo pair,
//   free), channel (used by free only) and owner_id. rsp returns exactly one
//   word per request: status (ok, no free channel or pair, owner mismatch)
//   and granted_channel (the channel, or the left channel of a stereo pair;
//   the requested channel echoed back on free).
//   Both channels move a word when valid and ready are high at a clock edge.
//
// Sequence:
//   On acceptance the request word is latched, the owner memory row of the
//   named channel and its partner is read and the lowest free channel and
//   lowest free pair are found from the state flags by priority encoders.
//   The execute step then updates the tables and loads the result register,
//   waiting while the register still holds an unaccepted response. No new
//   request is taken until that step is done; the read-then-update
//   sequence of the owner memory sets this.
//
// Reset (rst, synchronous, active high): all channels free, all owners
//   reading as zero, no response pending; no clearing pass is needed.
// Stall: the result register holds while rsp.ready is low; a new request is
//   still taken, and its update waits until the register is free.
module mono_stereo_voice_allocator_top import msva_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  msva_req_if.sink    req,
  msva_rsp_if.source  rsp
);

  msva_cmd_t cmd;

  // Sequence each request: take, then update and present.
  msva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Hold channel tables, search for free channels, form the response word.
  msva_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .in_cmd          (req.cmd),
    .in_channel      (req.channel),
    .in_owner_id     (req.owner_id),
    .status          (rsp.status),
    .granted_channel (rsp.granted_channel)
  );

endmodule

// File: tb/mono_stereo_voice_allocator_top_tb.sv
// Self-checking testbench of the voice allocator: directed, back-pressure and random request words.
`timescale 1ns / 100ps

module mono_stereo_voice_allocator_top_tb;
  import msva_pkg::*;

  // cmd 3 has no name in the package; the block treats it as a stereo request
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int TARGET_WORDS = 1050;   // request words for the whole run
  localparam int IDLE_LIMIT   = 1000;   // cycles without any handshake before giving up
  localparam int HOLD_OFF     = 60;     // long response stall of the pressure test
  localparam int REPORT_MAX   = 10;     // mismatches printed in full

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CHAN_W-1:0] granted_channel;
  } voice_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  msva_req_if req ();
  msva_rsp_if rsp ();

  mono_stereo_voice_allocator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the channel table, advanced once per accepted request word.
  logic [1:0]         voice_state [NUM_CHANNELS];
  logic [OWNER_W-1:0] voice_owner [NUM_CHANNELS];

  voice_rsp_t rsp_expect_q [$];
  voice_rsp_t want_rsp;

  int error_count   = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int idle_cycles   = 0;
  int hold_off_req  = 0;   // handed to the response sink, which counts it down itself
  int n_mono = 0, n_stereo = 0, n_free = 0;
  int n_ok = 0, n_full = 0, n_owner = 0;

  // --------------------------------------------------------------------------
  // Predictor: first-fit mono and stereo allocation, owner-checked free.
  // --------------------------------------------------------------------------
  function automatic voice_rsp_t predict_grant(input logic [CMD_W-1:0]   cmd,
                                               input logic [CHAN_W-1:0]  ch,
                                               input logic [OWNER_W-1:0] owner);
    voice_rsp_t r;
    int         partner;
    bit         found;
    r.status          = STAT_NOFREE;
    r.granted_channel = '0;
    partner           = -1;
    found             = 1'b0;
    if (cmd == CMD_MONO) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && voice_state[i] == ST_FREE) begin
          found             = 1'b1;
          voice_state[i]    = ST_MONO;
          voice_owner[i]    = owner;
          r.status          = STAT_OK;
          r.granted_channel = CHAN_W'(i);
        end
      end
    end else if (cmd == CMD_FREE) begin
      r.granted_channel = ch;
      if (int'(ch) >= NUM_CHANNELS) begin
        r.status = STAT_NOFREE;
      end else if (voice_owner[ch] != owner) begin
        r.status = STAT_OWNER;
      end else begin
        if (voice_state[ch] == ST_LEFT) begin
          partner = int'(ch) + 1;
        end else if (voice_state[ch] == ST_RIGHT && ch != 0) begin
          partner = int'(ch) - 1;
        end
        voice_state[ch] = ST_FREE;
        voice_owner[ch] = '0;
        // the partner goes only if it still belongs to the same owner
        if (partner >= 0 && partner < NUM_CHANNELS && voice_owner[partner] == owner) begin
          voice_state[partner] = ST_FREE;
          voice_owner[partner] = '0;
        end
        r.status = STAT_OK;
      end
    end else begin
      // stereo, and the spare code as well: lowest wholly free even/odd pair
      for (int i = 1; i < NUM_CHANNELS; i += 2) begin
        if (!found && voice_state[i] == ST_FREE && voice_state[i-1] == ST_FREE) begin
          found             = 1'b1;
          voice_state[i]    = ST_RIGHT;
          voice_state[i-1]  = ST_LEFT;
          voice_owner[i]    = owner;
          voice_owner[i-1]  = owner;
          r.status          = STAT_OK;
          r.granted_channel = CHAN_W'(i - 1);
        end
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request word from the next falling edge and hold it until taken.
  task automatic send_request(input logic [CMD_W-1:0]   cmd,
                              input logic [CHAN_W-1:0]  ch,
                              input logic [OWNER_W-1:0] owner);
    voice_rsp_t exp_rsp;
    @(negedge clk);
    req.valid    <= 1'b1;
    req.cmd      <= cmd;
    req.channel  <= ch;
    req.owner_id <= owner;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    exp_rsp = predict_grant(cmd, ch, owner);
    rsp_expect_q.push_back(exp_rsp);
    sent_count++;
    if (cmd == CMD_MONO) n_mono++;
    else if (cmd == CMD_FREE) n_free++;
    else n_stereo++;
    if (exp_rsp.status == STAT_OK) n_ok++;
    else if (exp_rsp.status == STAT_NOFREE) n_full++;
    else n_owner++;
  endtask

  // Drop valid for a number of cycles.
  task automatic idle_request(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
  endtask

  // Hold the request side quiet until every expected response word is back.
  task automatic wait_drained();
    idle_request(1);
    while (rsp_expect_q.size() != 0) @(negedge clk);
  endtask

  // Owner ids: the extremes, a small shared pool, and random values.
  function automatic logic [OWNER_W-1:0] pick_owner();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(4, 1);
      default: return $urandom();
    endcase
  endfunction

  // A channel that is in use, starting the search at a random place; the start channel itself if none is.
  function automatic logic [CHAN_W-1:0] pick_busy_channel();
    int start;
    int idx;
    start = $urandom_range(NUM_CHANNELS - 1);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      idx = (start + k) % NUM_CHANNELS;
      if (voice_state[idx] != ST_FREE) return CHAN_W'(idx);
    end
    return CHAN_W'(start);
  endfunction

  // Build one random request word; alloc_pct steers toward filling or draining.
  task automatic send_random_request(input int alloc_pct);
    logic [CMD_W-1:0]   cmd;
    logic [CHAN_W-1:0]  ch;
    logic [OWNER_W-1:0] owner;
    int                 roll;
    if ($urandom_range(99) < alloc_pct) begin
      roll  = $urandom_range(9);
      cmd   = (roll < 5) ? CMD_MONO : (roll < 9) ? CMD_STEREO : CMD_SPARE;
      ch    = CHAN_W'($urandom());  // ignored by allocation, but toggles every bit
      owner = pick_owner();
    end else begin
      cmd  = CMD_FREE;
      roll = $urandom_range(99);
      ch   = pick_busy_channel();
      if (roll < 75) begin
        owner = voice_owner[ch];     // well-formed release
      end else if (roll < 88) begin
        owner = voice_owner[ch] ^ (32'h1 << $urandom_range(31));
      end else begin
        ch    = CHAN_W'($urandom());
        owner = (roll < 94) ? '0 : pick_owner();
      end
    end
    send_request(cmd, ch, owner);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every command and the special cases on a near-empty table.
  task automatic test_directed();
    send_request(CMD_FREE,   6'd0,  32'h0000_0000);  // free a never-used channel, owner zero
    send_request(CMD_FREE,   6'd63, 32'h0000_0005);  // owner mismatch on an idle channel
    send_request(CMD_MONO,   6'd63, 32'hFFFF_FFFF);  // takes channel 0
    send_request(CMD_STEREO, 6'd0,  32'h0000_0000);  // pair 0/1 is split, so 2/3
    send_request(CMD_SPARE,  6'd21, 32'hA5A5_A5A5);  // spare code allocates pair 4/5
    send_request(CMD_MONO,   6'd42, 32'h0000_0001);  // fills the hole at channel 1
    send_request(CMD_STEREO, 6'd0,  32'h5A5A_5A5A);  // pair 6/7
    send_request(CMD_FREE,   6'd0,  32'h0000_0000);  // wrong owner
    send_request(CMD_FREE,   6'd0,  32'hFFFF_FFFF);  // release mono channel 0
    send_request(CMD_MONO,   6'd0,  32'h8000_0001);  // reuses channel 0
    send_request(CMD_FREE,   6'd3,  32'h0000_0000);  // release right half: pair 2/3 goes
    send_request(CMD_FREE,   6'd4,  32'hA5A5_A5A4);  // near-miss owner on a left half
    send_request(CMD_FREE,   6'd4,  32'hA5A5_A5A5);  // release left half: pair 4/5 goes
    send_request(CMD_FREE,   6'd7,  32'h5A5A_5A5A);  // pair 6/7 by its right half
    send_request(CMD_FREE,   6'd42, 32'h0000_0000);  // idle channel again, owner zero
    send_request(CMD_FREE,   6'd21, 32'h0000_0001);  // idle channel, nonzero owner
    send_request(CMD_MONO,   6'd0,  32'h0000_0001);  // first fit from the bottom again
    wait_drained();
  endtask

  // Stall the response side for a long stretch while request words keep coming,
  // so the block fills and drops req.ready; then pause until everything is back.
  task automatic test_backpressure();
    hold_off_req = HOLD_OFF;
    repeat (16) send_random_request(60);
    wait_drained();
  endtask

  // Alternate fill-heavy and drain-heavy rounds; the first round only allocates,
  // which runs the table dry for both mono and stereo requests.
  task automatic test_random();
    int round;
    int len;
    int alloc_pct;
    int burst_left;
    round      = 0;
    burst_left = 0;
    while (sent_count < TARGET_WORDS) begin
      alloc_pct = (round == 0) ? 100 : (round % 2 == 1) ? 20 : 75;
      len       = (round == 0) ? 90 : $urandom_range(40, 120);
      for (int n = 0; n < len && sent_count < TARGET_WORDS; n++) begin
        if (burst_left == 0) begin
          idle_request($urandom_range(0, 6));
          burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        end
        burst_left--;
        send_random_request(alloc_pct);
      end
      round++;
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stall pattern, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rsp_sink
    int   stall_left;
    int   run_left;
    logic run_ready;
    stall_left = 0;
    run_left   = 0;
    run_ready  = 1'b0;
    rsp.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        stall_left   = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = ~run_ready;
          if (run_ready) begin
            run_left = ($urandom_range(5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
          end else begin
            run_left = $urandom_range(1, 4);
          end
        end
        run_left--;
        rsp.ready <= run_ready;
      end
    end
  end

  // Compare each accepted response word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      checked_count++;
      if (rsp_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("%0t: response word with none expected: status %0d channel %0d",
                   $realtime, rsp.status, rsp.granted_channel);
      end else begin
        want_rsp = rsp_expect_q.pop_front();
        if (rsp.status !== want_rsp.status ||
            rsp.granted_channel !== want_rsp.granted_channel) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: response %0d: expected status %0d channel %0d, got status %0d channel %0d",
                     $realtime, checked_count, want_rsp.status, want_rsp.granted_channel,
                     rsp.status, rsp.granted_channel);
        end
      end
    end
  end

  // Abort when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
               IDLE_LIMIT, rsp_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    req.valid    = 1'b0;
    req.cmd      = CMD_MONO;
    req.channel  = '0;
    req.owner_id = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      voice_state[i] = ST_FREE;
      voice_owner[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_backpressure();
    test_random();

    // watch for stray response words before the summary
    repeat (8) @(posedge clk);
    $display("ran %0d request words: %0d mono, %0d stereo, %0d free; %0d responses checked",
             sent_count, n_mono, n_stereo, n_free, checked_count);
    $display("outcomes: %0d ok, %0d refused on a full table, %0d owner rejects; %0d errors",
             n_ok, n_full, n_owner, error_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: mono_stereo_voice_allocator_top.f
src/msva_pkg.sv
src/msva_req_if.sv
src/msva_rsp_if.sv
src/msva_ctrl.sv
src/msva_dp.sv
src/mono_stereo_voice_allocator_top.sv
tb/mono_stereo_voice_allocator_top_tb.sv
